### rtl/wpm_pkg.sv
// Word pattern matcher package: sizes, character codes, status codes,
// sequencer and pattern-walk state types, character class helpers.
// No dependencies.
`default_nettype none

package wpm_pkg;

   localparam int MAX_PATTERN   = 16;
   localparam int POSITION_BITS = 16;
   localparam int PATTERN_SLOTS = 16;
   localparam int LENGTH_CAP    = (MAX_PATTERN < PATTERN_SLOTS) ? MAX_PATTERN : PATTERN_SLOTS;
   localparam int INDEX_BITS    = 5;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 64;
   localparam int START_BITS    = 16;

   localparam logic [1:0] REG_LENGTH = 2'd0;
   localparam logic [1:0] REG_LOW    = 2'd1;
   localparam logic [1:0] REG_HIGH   = 2'd2;

   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_DOT       = 8'h2E;
   localparam logic [7:0] CHAR_LBRACKET  = 8'h5B;
   localparam logic [7:0] CHAR_CARET     = 8'h5E;
   localparam logic [7:0] CHAR_RBRACKET  = 8'h5D;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z   = 8'h7A;
   localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z   = 8'h5A;

   typedef enum logic [1:0] {
      STATUS_FOUND,
      STATUS_NOT_FOUND,
      STATUS_BAD_PATTERN,
      STATUS_BAD_SOURCE
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STEP,
      ST_ESCAPE,
      ST_CLASS,
      ST_CHECK,
      ST_RESULT
   } state_type;

   typedef enum logic [1:0] {
      WALK_PLAIN,
      WALK_ESCAPE,
      WALK_CLASS_OPEN,
      WALK_CLASS
   } walk_type;

   function automatic logic is_upper(input logic [7:0] c);
      return (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z);
   endfunction

   function automatic logic is_lower(input logic [7:0] c);
      return (c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z);
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return is_upper(c) || is_lower(c);
   endfunction

   function automatic logic is_pattern_char(input logic [7:0] c);
      return is_letter(c) || (c == CHAR_LBRACKET) || (c == CHAR_RBRACKET)
         || (c == CHAR_CARET) || (c == CHAR_BACKSLASH) || (c == CHAR_DOT);
   endfunction

endpackage

`default_nettype wire

### rtl/word_pattern_matcher_unit.sv
// Word pattern matcher top level: request/response channels, CSR port,
// sequencer around one shared pattern read and compare unit.
// Depends on wpm_pkg.
`default_nettype none

// Text streams in one character per request on req_*; the request marked
// req_last closes the text and yields exactly one response on rsp_*
// (status and start position of the first word-ending match).
// The pattern lives in three CSRs on the csr_* port (length at 0x00,
// characters 0-7 at 0x08, characters 8-15 at 0x10); write them only
// between texts.
// Each character is accepted, then passes the step state; a backslash
// element adds the escape state, and a [set] element adds the class state,
// which scans the pattern characters after its opening bracket up to the
// closing bracket, or past the pattern end when none follows. The final
// character then adds the pattern check over every pattern character, the
// close of the check and the result state.
// The single pattern read port serves all of these states, one pattern
// character per cycle.
// The response sits in an output register: new characters are accepted
// while it waits, and only the next final character holds in its result
// state until rsp_ready frees the register.
// Synchronous reset clears the CSRs, the sequencer state, the stream position and match state, and the response valid.
module word_pattern_matcher_unit #(
   parameter int POSITION_BITS = wpm_pkg::POSITION_BITS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [7:0]                         req_source_char,
   input  wire logic                               req_last,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [1:0]                              rsp_status,
   output logic [wpm_pkg::START_BITS-1:0]          rsp_match_start,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [wpm_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  wire logic [wpm_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [wpm_pkg::CSR_DATA_BITS-1:0]       csr_prdata,
   output logic                                    csr_pready
);

   localparam int IB = wpm_pkg::INDEX_BITS;
   localparam int WideBits = (POSITION_BITS > wpm_pkg::START_BITS)
                             ? POSITION_BITS : wpm_pkg::START_BITS;
   localparam logic [IB-1:0] LengthCap = IB'(wpm_pkg::LENGTH_CAP);

   // configuration
   logic [IB-1:0] len_ff, len_in;
   logic [63:0]   pat_low_ff, pat_low_in;
   logic [63:0]   pat_high_ff, pat_high_in;

   // request and stream state
   logic [7:0]               char_ff, char_in;
   logic                     last_ff, last_in;
   logic [IB-1:0]            index_ff, index_in;
   logic [POSITION_BITS-1:0] cand_ff, cand_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] found_start_ff, found_start_in;
   logic                     pending_ff, pending_in;
   logic                     found_ff, found_in;
   logic                     bad_source_ff, bad_source_in;

   // scan unit
   logic [IB-1:0]          scan_ff, scan_in;
   logic                   open_ff, open_in;
   logic                   neg_ff, neg_in;
   logic                   hit_ff, hit_in;
   logic                   ok_ff, ok_in;
   wpm_pkg::walk_type      walk_ff, walk_in;
   wpm_pkg::state_type     state_ff, state_in;

   // response register
   logic                         rsp_valid_ff, rsp_valid_in;
   wpm_pkg::status_type          rsp_status_ff, rsp_status_in;
   logic [wpm_pkg::START_BITS-1:0] rsp_start_ff, rsp_start_in;

   logic [127:0]  pattern_bits;
   logic [IB-1:0] m_eff;
   logic          in_range;
   logic [7:0]    pc;
   logic          c_space;
   logic          req_take;
   logic          csr_write;
   logic          out_free;
   logic          done;
   logic          apply;
   logic          go_escape;
   logic          go_class;
   logic [IB-1:0] adv;
   logic [IB-1:0] j_new;
   logic [WideBits-1:0] found_wide;

   assign pattern_bits = {pat_high_ff, pat_low_ff};
   assign m_eff        = (len_ff > LengthCap) ? LengthCap : len_ff;
   assign in_range     = scan_ff < m_eff;
   assign pc           = in_range ? pattern_bits[{scan_ff[3:0], 3'b000} +: 8] : 8'd0;
   assign c_space      = char_ff == wpm_pkg::CHAR_SPACE;
   assign req_take     = req_valid && req_ready;
   assign csr_write    = csr_psel && csr_penable && csr_pwrite;
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign found_wide   = WideBits'(found_start_ff);

   // shared step unit: one pattern character per cycle
   always_comb begin
      done      = 1'b0;
      apply     = 1'b0;
      go_escape = 1'b0;
      go_class  = 1'b0;
      adv       = index_ff;
      unique case (state_ff)
         wpm_pkg::ST_STEP: begin
            priority if (found_ff || (pending_ff && c_space)) begin
               done = 1'b1;
            end else if (c_space) begin
               done  = 1'b1;
               apply = 1'b1;
               adv   = '0;
            end else if (index_ff >= m_eff) begin
               done  = 1'b1;
               apply = 1'b1;
            end else if (pc == wpm_pkg::CHAR_BACKSLASH) begin
               go_escape = 1'b1;
            end else if (pc == wpm_pkg::CHAR_DOT) begin
               done  = 1'b1;
               apply = 1'b1;
               adv   = index_ff + IB'(1);
            end else if (pc == wpm_pkg::CHAR_LBRACKET) begin
               go_class = 1'b1;
            end else begin
               done  = 1'b1;
               apply = 1'b1;
               adv   = (char_ff == pc) ? index_ff + IB'(1) : index_ff;
            end
         end
         wpm_pkg::ST_ESCAPE: begin
            done  = 1'b1;
            apply = 1'b1;
            if (((pc == wpm_pkg::CHAR_LOWER_A) && wpm_pkg::is_lower(char_ff))
                  || ((pc == wpm_pkg::CHAR_UPPER_A) && wpm_pkg::is_upper(char_ff))) begin
               adv = index_ff + IB'(2);
            end
         end
         wpm_pkg::ST_CLASS: begin
            priority if (!in_range) begin
               done  = 1'b1;
               apply = 1'b1;
            end else if (open_ff && (pc == wpm_pkg::CHAR_CARET)) begin
               done = 1'b0;
            end else if (pc == wpm_pkg::CHAR_RBRACKET) begin
               done  = 1'b1;
               apply = 1'b1;
               adv   = (hit_ff ^ neg_ff) ? scan_ff + IB'(1) : index_ff;
            end else begin
               done = 1'b0;
            end
         end
         default: begin
            done = 1'b0;
         end
      endcase
   end

   assign j_new = ((adv == index_ff) || (adv > m_eff)) ? '0 : adv;

   // next state
   always_comb begin
      state_in = state_ff;
      priority if (done) begin
         state_in = last_ff ? wpm_pkg::ST_CHECK : wpm_pkg::ST_IDLE;
      end else begin
         unique case (state_ff)
            wpm_pkg::ST_IDLE: begin
               if (req_take) state_in = wpm_pkg::ST_STEP;
            end
            wpm_pkg::ST_STEP: begin
               priority if (go_escape) state_in = wpm_pkg::ST_ESCAPE;
               else if (go_class)      state_in = wpm_pkg::ST_CLASS;
               else                    state_in = wpm_pkg::ST_STEP;
            end
            wpm_pkg::ST_ESCAPE: begin
               state_in = wpm_pkg::ST_ESCAPE;
            end
            wpm_pkg::ST_CLASS: begin
               state_in = wpm_pkg::ST_CLASS;
            end
            wpm_pkg::ST_CHECK: begin
               if (!in_range) state_in = wpm_pkg::ST_RESULT;
            end
            wpm_pkg::ST_RESULT: begin
               if (out_free) state_in = wpm_pkg::ST_IDLE;
            end
            default: begin
               state_in = wpm_pkg::ST_IDLE;
            end
         endcase
      end
   end

   // outputs
   always_comb begin
      req_ready       = state_ff == wpm_pkg::ST_IDLE;
      rsp_valid       = rsp_valid_ff;
      rsp_status      = rsp_status_ff;
      rsp_match_start = rsp_start_ff;
      csr_pready      = 1'b1;
      unique case (csr_paddr[4:3])
         wpm_pkg::REG_LENGTH: csr_prdata = {{(wpm_pkg::CSR_DATA_BITS-IB){1'b0}}, len_ff};
         wpm_pkg::REG_LOW:    csr_prdata = pat_low_ff;
         wpm_pkg::REG_HIGH:   csr_prdata = pat_high_ff;
         default:             csr_prdata = '0;
      endcase
   end

   // datapath
   always_comb begin
      len_in         = len_ff;
      pat_low_in     = pat_low_ff;
      pat_high_in    = pat_high_ff;
      char_in        = char_ff;
      last_in        = last_ff;
      index_in       = index_ff;
      cand_in        = cand_ff;
      pos_in         = pos_ff;
      found_start_in = found_start_ff;
      pending_in     = pending_ff;
      found_in       = found_ff;
      bad_source_in  = bad_source_ff;
      scan_in        = scan_ff;
      open_in        = open_ff;
      neg_in         = neg_ff;
      hit_in         = hit_ff;
      ok_in          = ok_ff;
      walk_in        = walk_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_start_in   = rsp_start_ff;
      rsp_valid_in   = rsp_ready ? 1'b0 : rsp_valid_ff;

      if (csr_write) begin
         unique case (csr_paddr[4:3])
            wpm_pkg::REG_LENGTH: len_in      = csr_pwdata[IB-1:0];
            wpm_pkg::REG_LOW:    pat_low_in  = csr_pwdata;
            wpm_pkg::REG_HIGH:   pat_high_in = csr_pwdata;
            default:             len_in      = len_ff;
         endcase
      end

      unique case (state_ff)
         wpm_pkg::ST_IDLE: begin
            if (req_take) begin
               char_in = req_source_char;
               last_in = req_last;
               scan_in = index_ff;
            end
         end
         wpm_pkg::ST_STEP: begin
            if (!wpm_pkg::is_letter(char_ff) && !c_space) bad_source_in = 1'b1;
            if (pos_ff != '1) pos_in = pos_ff + POSITION_BITS'(1);
            if (!found_ff) begin
               if (pending_ff && c_space) begin
                  found_in       = 1'b1;
                  found_start_in = cand_ff;
               end else begin
                  pending_in = 1'b0;
                  if (!c_space && (index_ff == '0)) cand_in = pos_ff;
               end
            end
            scan_in = scan_ff + IB'(1);
            open_in = 1'b1;
            neg_in  = 1'b0;
            hit_in  = 1'b0;
         end
         wpm_pkg::ST_CLASS: begin
            if (in_range) begin
               scan_in = scan_ff + IB'(1);
               open_in = 1'b0;
               if (open_ff && (pc == wpm_pkg::CHAR_CARET)) begin
                  neg_in = 1'b1;
               end else if (pc == char_ff) begin
                  hit_in = 1'b1;
               end
            end
         end
         wpm_pkg::ST_CHECK: begin
            if (in_range) begin
               scan_in = scan_ff + IB'(1);
               if (!wpm_pkg::is_pattern_char(pc)) ok_in = 1'b0;
               unique case (walk_ff)
                  wpm_pkg::WALK_PLAIN: begin
                     if (pc == wpm_pkg::CHAR_BACKSLASH)     walk_in = wpm_pkg::WALK_ESCAPE;
                     else if (pc == wpm_pkg::CHAR_LBRACKET) walk_in = wpm_pkg::WALK_CLASS_OPEN;
                  end
                  wpm_pkg::WALK_ESCAPE: begin
                     walk_in = wpm_pkg::WALK_PLAIN;
                  end
                  wpm_pkg::WALK_CLASS_OPEN: begin
                     walk_in = (pc == wpm_pkg::CHAR_RBRACKET) ? wpm_pkg::WALK_PLAIN
                                                              : wpm_pkg::WALK_CLASS;
                  end
                  wpm_pkg::WALK_CLASS: begin
                     if (pc == wpm_pkg::CHAR_RBRACKET) walk_in = wpm_pkg::WALK_PLAIN;
                  end
                  default: begin
                     walk_in = wpm_pkg::WALK_PLAIN;
                  end
               endcase
            end
         end
         wpm_pkg::ST_RESULT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_start_in = '0;
               priority if (!ok_ff || (walk_ff == wpm_pkg::WALK_CLASS_OPEN)
                            || (walk_ff == wpm_pkg::WALK_CLASS)) begin
                  rsp_status_in = wpm_pkg::STATUS_BAD_PATTERN;
               end else if (bad_source_ff) begin
                  rsp_status_in = wpm_pkg::STATUS_BAD_SOURCE;
               end else if (found_ff) begin
                  rsp_status_in = wpm_pkg::STATUS_FOUND;
                  rsp_start_in  = (found_wide > WideBits'({wpm_pkg::START_BITS{1'b1}}))
                                  ? '1 : found_wide[wpm_pkg::START_BITS-1:0];
               end else begin
                  rsp_status_in = wpm_pkg::STATUS_NOT_FOUND;
               end
               index_in       = '0;
               cand_in        = '0;
               pos_in         = '0;
               found_start_in = '0;
               pending_in     = 1'b0;
               found_in       = 1'b0;
               bad_source_in  = 1'b0;
            end
         end
         default: begin
            scan_in = scan_ff;
         end
      endcase

      // commit the new pattern index once the step unit is through
      if (apply) begin
         index_in = j_new;
         if ((m_eff != '0) && (j_new == m_eff)) begin
            if (last_ff) begin
               found_in       = 1'b1;
               found_start_in = cand_in;
            end else begin
               pending_in = 1'b1;
            end
         end
      end

      // start the pattern check after the final request
      if (done && last_ff) begin
         scan_in = '0;
         ok_in   = 1'b1;
         walk_in = wpm_pkg::WALK_PLAIN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= wpm_pkg::ST_IDLE;
         len_ff         <= '0;
         pat_low_ff     <= '0;
         pat_high_ff    <= '0;
         index_ff       <= '0;
         cand_ff        <= '0;
         pos_ff         <= '0;
         found_start_ff <= '0;
         pending_ff     <= 1'b0;
         found_ff       <= 1'b0;
         bad_source_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         len_ff         <= len_in;
         pat_low_ff     <= pat_low_in;
         pat_high_ff    <= pat_high_in;
         index_ff       <= index_in;
         cand_ff        <= cand_in;
         pos_ff         <= pos_in;
         found_start_ff <= found_start_in;
         pending_ff     <= pending_in;
         found_ff       <= found_in;
         bad_source_ff  <= bad_source_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff       <= char_in;
      last_ff       <= last_in;
      scan_ff       <= scan_in;
      open_ff       <= open_in;
      neg_ff        <= neg_in;
      hit_ff        <= hit_in;
      ok_ff         <= ok_in;
      walk_ff       <= walk_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
   end

endmodule

`default_nettype wire
